@@ design/triangle_contour_band_splitter_assert.svh @@
// assertion macros used by the checker file
`ifndef TRIANGLE_CONTOUR_BAND_SPLITTER_ASSERT_SVH
`define TRIANGLE_CONTOUR_BAND_SPLITTER_ASSERT_SVH
// property that must hold at every clock edge outside reset
`define TCBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked also during reset
`define TCBS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/tcbs_pkg.sv @@
// package with shared constants, types and the sequencer state encoding
package tcbs_pkg;
   localparam int BANDS_DEFAULT = 20;
   localparam int CORD_W        = 32;
   localparam int LEVEL_W       = 6;
   localparam int FRAC_W        = 17;
   localparam logic [16:0] FRAC_ONE = 17'h10000;
   localparam logic CSR_HEIGHT_LOW  = 1'b0;
   localparam logic CSR_HEIGHT_HIGH = 1'b1;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'h0001,
      ST_CROSS  = 13'h0002,
      ST_SORT   = 13'h0004,
      ST_BAND   = 13'h0008,
      ST_BDIV   = 13'h0010,
      ST_PLAN   = 13'h0020,
      ST_FSET   = 13'h0040,
      ST_FDIV   = 13'h0080,
      ST_LERP   = 13'h0100,
      ST_LMUL   = 13'h0200,
      ST_EMIT   = 13'h0400,
      ST_WAIT   = 13'h0800,
      ST_NEXT   = 13'h1000
   } state_type;
endpackage

@@ design/triangle_contour_band_splitter.sv @@
// Triangle filled-contour band splitter: one triangle in, its band polygons out, or
// the whole triangle when it lies in a single band. After a triangle is accepted, the
// cross product is formed and the corners are sorted, so an empty height range or a
// zero-area triangle frees the block with no result. Otherwise the three band indices
// are found in turn on one shared 64-bit restoring divider (one quotient bit a cycle),
// and if all three are equal the whole triangle is handed to the output register.
// Otherwise each band polygon sets its edge fractions in turn, using the divider
// for every fraction that is not flat or clamped, then one 17x33 multiplier forms the
// eight interpolated coordinates one after another, and the polygon is loaded into the
// output register. A stalled output register adds its stall. req_tready is high only
// while no triangle is held.
module triangle_contour_band_splitter #(
   parameter int BANDS = tcbs_pkg::BANDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz from bit 0 up
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y, band_level from bit 0 up, zero filled
   output logic [263:0] rsp_tdata,
   // is_quad
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);
   localparam int DW = 64;

   tcbs_pkg::state_type state_ff, state_in;
   logic signed [31:0] hlow_ff, hlow_in, hhigh_ff, hhigh_in;
   logic signed [31:0] cx_ff [3], cx_in [3];
   logic signed [31:0] cy_ff [3], cy_in [3];
   logic signed [31:0] cz_ff [3], cz_in [3];
   logic [1:0]         ord_ff [3], ord_in [3];
   logic signed [6:0]  bnd_ff [3], bnd_in [3];
   logic [1:0]         bsel_ff, bsel_in;
   logic signed [6:0]  iz_ff, iz_in;
   logic               half_ff, half_in;
   logic [1:0]         fsel_ff, fsel_in;
   logic [16:0]        frac_ff [4], frac_in [4];
   logic [2:0]         vsel_ff, vsel_in;
   logic signed [31:0] vout_ff [8], vout_in [8];
   logic [6:0]         mstep_ff, mstep_in;
   logic signed [65:0] cross_ff, cross_in;
   // shared divider
   logic [DW-1:0]      dnum_ff, dnum_in, dden_ff, dden_in, dq_ff, dq_in;
   logic [DW:0]        drem_ff, drem_in;
   logic               dneg_ff, dneg_in;
   logic [6:0]         dcnt_ff, dcnt_in;
   // shared multiplier product
   logic signed [50:0] prod_ff, prod_in;
   logic [263:0]       odata_ff, odata_in;
   logic               ouser_ff, ouser_in, olast_ff, olast_in, ovalid_ff, ovalid_in;

   logic signed [33:0] span;
   logic signed [32:0] dx1, dy1, dx2, dy2;
   logic signed [39:0] bnum;
   logic signed [6:0]  iend;
   logic [1:0]         e_lo, e_hi;
   logic signed [39:0] fden, fnum;
   logic [16:0]        flat;
   logic signed [31:0] lbase, lend;
   logic [16:0]        lf;
   logic signed [32:0] ldiff;
   logic [DW:0]        rtrial;
   logic signed [63:0] bq;
   logic signed [6:0]  bsat;
   logic               last_poly;

   always_comb begin
      span = 34'(hhigh_ff) - 34'(hlow_ff);
      dx1  = 33'(cx_ff[1]) - 33'(cx_ff[0]);
      dy1  = 33'(cy_ff[1]) - 33'(cy_ff[0]);
      dx2  = 33'(cx_ff[2]) - 33'(cx_ff[0]);
      dy2  = 33'(cy_ff[2]) - 33'(cy_ff[0]);
      bnum = (40'(cz_ff[ord_ff[bsel_ff]]) - 40'(hlow_ff)) * 40'(BANDS);
      iend = half_ff ? bnd_ff[2] : bnd_ff[1];
      // edges of the current fraction: 0/1 lower bound edges, 2/3 upper bound
      if (!half_ff) begin
         e_lo = 2'd0;
         e_hi = fsel_ff[0] ? 2'd2 : 2'd1;
      end else begin
         e_lo = fsel_ff[0] ? 2'd1 : 2'd0;
         e_hi = 2'd2;
      end
      fden = (40'(cz_ff[ord_ff[e_hi]]) - 40'(cz_ff[ord_ff[e_lo]])) * 40'(BANDS);
      fnum = (40'(hlow_ff) - 40'(cz_ff[ord_ff[e_lo]])) * 40'(BANDS)
           + 40'(fsel_ff[1] ? iz_ff + 7'sd1 : iz_ff) * 40'(span);
      flat = fsel_ff[1] ? tcbs_pkg::FRAC_ONE : 17'd0;
      // vertex vsel: pair index vsel[2:1], coord vsel[0]
      case (vsel_ff[2:1])
         2'd0: lf = frac_ff[0];
         2'd1: lf = frac_ff[2];
         2'd2: lf = frac_ff[3];
         default: lf = frac_ff[1];
      endcase
      if (!half_ff) begin
         lbase = vsel_ff[0] ? cy_ff[ord_ff[0]] : cx_ff[ord_ff[0]];
         if (vsel_ff[2:1] == 2'd0 || vsel_ff[2:1] == 2'd1)
            lend = vsel_ff[0] ? cy_ff[ord_ff[1]] : cx_ff[ord_ff[1]];
         else
            lend = vsel_ff[0] ? cy_ff[ord_ff[2]] : cx_ff[ord_ff[2]];
      end else begin
         if (vsel_ff[2:1] == 2'd0 || vsel_ff[2:1] == 2'd1)
            lbase = vsel_ff[0] ? cy_ff[ord_ff[0]] : cx_ff[ord_ff[0]];
         else
            lbase = vsel_ff[0] ? cy_ff[ord_ff[1]] : cx_ff[ord_ff[1]];
         lend = vsel_ff[0] ? cy_ff[ord_ff[2]] : cx_ff[ord_ff[2]];
      end
      ldiff  = 33'(lend) - 33'(lbase);
      rtrial = {drem_ff[DW-1:0], dnum_ff[DW-1]} - {1'b0, dden_ff};
      bq     = dneg_ff ? -$signed(dq_ff) - ((drem_ff != '0) ? 64'sd1 : 64'sd0)
                       : $signed(dq_ff);
      if (bq < -64'sd1)               bsat = -7'sd1;
      else if (bq > 64'(BANDS))       bsat = 7'(BANDS);
      else                            bsat = 7'(bq);
      last_poly = (iz_ff == iend) && (half_ff || !(bnd_ff[1] < bnd_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      hlow_in = hlow_ff; hhigh_in = hhigh_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; ord_in = ord_ff; bnd_in = bnd_ff;
      bsel_in = bsel_ff; iz_in = iz_ff; half_in = half_ff; fsel_in = fsel_ff;
      frac_in = frac_ff; vsel_in = vsel_ff; vout_in = vout_ff; mstep_in = mstep_ff;
      cross_in = cross_ff; dnum_in = dnum_ff; dden_in = dden_ff; dq_in = dq_ff;
      drem_in = drem_ff; dneg_in = dneg_ff; dcnt_in = dcnt_ff; prod_in = prod_ff;
      odata_in = odata_ff; ouser_in = ouser_ff; olast_in = olast_ff;
      ovalid_in = ovalid_ff;
      if (rsp_tvalid && rsp_tready) ovalid_in = 1'b0;
      if (csr_we) begin
         case (csr_index)
            tcbs_pkg::CSR_HEIGHT_LOW:  hlow_in  = csr_wdata;
            tcbs_pkg::CSR_HEIGHT_HIGH: hhigh_in = csr_wdata;
            default: ;
         endcase
      end
      case (state_ff)
         tcbs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  cx_in[i] = req_tdata[96*i +: 32];
                  cy_in[i] = req_tdata[96*i+32 +: 32];
                  cz_in[i] = req_tdata[96*i+64 +: 32];
               end
               mstep_in = 7'd0;
               state_in = tcbs_pkg::ST_CROSS;
            end
         end
         tcbs_pkg::ST_CROSS: begin
            // two 33x33 products, one per cycle
            if (mstep_ff == 7'd0) begin
               cross_in = 66'(dx1) * 66'(dy2);
               mstep_in = 7'd1;
            end else begin
               cross_in = cross_ff - 66'(dx2) * 66'(dy1);
               state_in = tcbs_pkg::ST_SORT;
            end
         end
         tcbs_pkg::ST_SORT: begin
            if ($signed(hlow_ff) >= $signed(hhigh_ff) || cross_ff == '0) begin
               state_in = tcbs_pkg::ST_IDLE;
            end else begin
               if (cz_ff[0] <= cz_ff[1] && cz_ff[1] <= cz_ff[2])
                  ord_in = '{2'd0, 2'd1, 2'd2};
               else if (cz_ff[0] <= cz_ff[2] && cz_ff[2] <= cz_ff[1])
                  ord_in = '{2'd0, 2'd2, 2'd1};
               else if (cz_ff[1] <= cz_ff[2] && cz_ff[2] <= cz_ff[0])
                  ord_in = '{2'd1, 2'd2, 2'd0};
               else if (cz_ff[1] <= cz_ff[0] && cz_ff[0] <= cz_ff[2])
                  ord_in = '{2'd1, 2'd0, 2'd2};
               else if (cz_ff[2] <= cz_ff[0] && cz_ff[0] <= cz_ff[1])
                  ord_in = '{2'd2, 2'd0, 2'd1};
               else
                  ord_in = '{2'd2, 2'd1, 2'd0};
               bsel_in  = 2'd0;
               state_in = tcbs_pkg::ST_BAND;
            end
         end
         tcbs_pkg::ST_BAND: begin
            dneg_in  = bnum[39];
            dnum_in  = 64'(bnum[39] ? -bnum : bnum);
            dden_in  = 64'(span);
            dq_in    = '0;
            drem_in  = '0;
            dcnt_in  = 7'd0;
            state_in = tcbs_pkg::ST_BDIV;
         end
         tcbs_pkg::ST_BDIV, tcbs_pkg::ST_FDIV: begin
            // restoring division, one quotient bit per cycle
            if (!rtrial[DW]) begin
               drem_in = rtrial;
               dq_in   = {dq_ff[DW-2:0], 1'b1};
            end else begin
               drem_in = {drem_ff[DW-1:0], dnum_ff[DW-1]};
               dq_in   = {dq_ff[DW-2:0], 1'b0};
            end
            dnum_in = {dnum_ff[DW-2:0], 1'b0};
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'(DW-1)) begin
               if (state_ff == tcbs_pkg::ST_BDIV) begin
                  state_in = tcbs_pkg::ST_PLAN;
               end else begin
                  frac_in[fsel_ff] = dq_in[16:0];
                  state_in = tcbs_pkg::ST_NEXT;
               end
            end
         end
         tcbs_pkg::ST_PLAN: begin
            // the band index needs the remainder, so read it here
            bnd_in[bsel_ff] = bsat;
            if (bsel_ff != 2'd2) begin
               bsel_in  = bsel_ff + 2'd1;
               state_in = tcbs_pkg::ST_BAND;
            end else if (bnd_ff[0] == bnd_ff[1] && bnd_ff[1] == bsat) begin
               state_in = tcbs_pkg::ST_WAIT;
            end else begin
               half_in  = !(bnd_ff[0] < bnd_ff[1]);
               iz_in    = (bnd_ff[0] < bnd_ff[1]) ? bnd_ff[0] : bnd_ff[1];
               fsel_in  = 2'd0;
               state_in = tcbs_pkg::ST_FSET;
            end
         end
         tcbs_pkg::ST_FSET: begin
            if (fden == '0) begin
               frac_in[fsel_ff] = flat;
               state_in = tcbs_pkg::ST_NEXT;
            end else if (fnum <= 0) begin
               frac_in[fsel_ff] = 17'd0;
               state_in = tcbs_pkg::ST_NEXT;
            end else if (fnum >= fden) begin
               frac_in[fsel_ff] = tcbs_pkg::FRAC_ONE;
               state_in = tcbs_pkg::ST_NEXT;
            end else begin
               dnum_in  = 64'(fnum) << 16;
               dden_in  = 64'(fden);
               dq_in    = '0;
               drem_in  = '0;
               dcnt_in  = 7'd0;
               state_in = tcbs_pkg::ST_FDIV;
            end
         end
         tcbs_pkg::ST_NEXT: begin
            if (fsel_ff != 2'd3) begin
               fsel_in  = fsel_ff + 2'd1;
               state_in = tcbs_pkg::ST_FSET;
            end else begin
               vsel_in  = 3'd0;
               state_in = tcbs_pkg::ST_LERP;
            end
         end
         tcbs_pkg::ST_LERP: begin
            prod_in  = 51'($signed({1'b0, lf})) * 51'(ldiff);
            state_in = tcbs_pkg::ST_LMUL;
         end
         tcbs_pkg::ST_LMUL: begin
            vout_in[vsel_ff] = 32'(lbase + 32'(prod_ff >>> 16));
            if (vsel_ff != 3'd7) begin
               vsel_in  = vsel_ff + 3'd1;
               state_in = tcbs_pkg::ST_LERP;
            end else begin
               state_in = tcbs_pkg::ST_EMIT;
            end
         end
         tcbs_pkg::ST_EMIT: begin
            if (!ovalid_ff || rsp_tready) begin
               odata_in = '0;
               for (int i = 0; i < 8; i++) odata_in[32*i +: 32] = vout_ff[i];
               odata_in[261:256] = 6'(iz_ff);
               ouser_in  = 1'b1;
               olast_in  = last_poly;
               ovalid_in = 1'b1;
               fsel_in   = 2'd0;
               if (last_poly) begin
                  state_in = tcbs_pkg::ST_IDLE;
               end else begin
                  if (iz_ff == iend) begin
                     half_in = 1'b1;
                     iz_in   = bnd_ff[1];
                  end else begin
                     iz_in   = iz_ff + 7'sd1;
                  end
                  state_in = tcbs_pkg::ST_FSET;
               end
            end
         end
         tcbs_pkg::ST_WAIT: begin
            // whole triangle goes out once the output register is free
            if (!ovalid_ff || rsp_tready) begin
               odata_in  = {2'b00, 6'(bnd_ff[0]),
                            cy_ff[ord_ff[2]], cx_ff[ord_ff[2]],
                            cy_ff[ord_ff[2]], cx_ff[ord_ff[2]],
                            cy_ff[ord_ff[1]], cx_ff[ord_ff[1]],
                            cy_ff[ord_ff[0]], cx_ff[ord_ff[0]]};
               ouser_in  = 1'b0;
               olast_in  = 1'b1;
               ovalid_in = 1'b1;
               state_in  = tcbs_pkg::ST_IDLE;
            end
         end
         default: state_in = tcbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tcbs_pkg::ST_IDLE;
         hlow_ff   <= '0;
         hhigh_ff  <= 32'sd65536;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hlow_ff   <= hlow_in;
         hhigh_ff  <= hhigh_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; ord_ff <= ord_in;
      bnd_ff <= bnd_in; bsel_ff <= bsel_in; iz_ff <= iz_in; half_ff <= half_in;
      fsel_ff <= fsel_in; frac_ff <= frac_in; vsel_ff <= vsel_in;
      vout_ff <= vout_in; mstep_ff <= mstep_in; cross_ff <= cross_in;
      dnum_ff <= dnum_in; dden_ff <= dden_in; dq_ff <= dq_in; drem_ff <= drem_in;
      dneg_ff <= dneg_in; dcnt_ff <= dcnt_in; prod_ff <= prod_in;
      odata_ff <= odata_in; ouser_ff <= ouser_in; olast_ff <= olast_in;
   end

   assign req_tready = (state_ff == tcbs_pkg::ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;
endmodule

@@ design/tcbs_checker.sv @@
// port-level checker for the band splitter, bound to the top level
`include "triangle_contour_band_splitter_assert.svh"
module tcbs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [263:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);
   `TCBS_ASSERT(a_hold_rsp, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `TCBS_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "accepted a transaction while busy")
   `TCBS_ASSERT(a_whole_is_last, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tlast, "whole triangle without last mark")
   `TCBS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")
endmodule

bind triangle_contour_band_splitter tcbs_checker u_tcbs_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
